// ===== rtl/variable_partition_allocator_unit_defines.svh =====
// Assertion helpers shared by the allocator RTL
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define VPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define VPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/vpa_pkg.sv =====
package vpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int SIZE_W     = 16;
    localparam int ID_W       = 8;

    localparam logic [SIZE_W-1:0] RESET_TOTAL = 16'd1024;

    // opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // fit policies
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    // register indexes
    localparam logic REG_FIT_POLICY   = 1'b0;
    localparam logic REG_MEMORY_TOTAL = 1'b1;

    // status codes
    localparam logic [3:0] STS_ALLOCATED    = 4'd0;
    localparam logic [3:0] STS_FAIL_FRAG    = 4'd1;
    localparam logic [3:0] STS_FAIL_SHORT   = 4'd2;
    localparam logic [3:0] STS_FREED        = 4'd3;
    localparam logic [3:0] STS_FREE_IGNORED = 4'd4;
    localparam logic [3:0] STS_DUPLICATE_ID = 4'd5;
    localparam logic [3:0] STS_ZERO_SIZE    = 4'd6;
    localparam logic [3:0] STS_RESTARTED    = 4'd7;
    localparam logic [3:0] STS_TABLE_FULL   = 4'd8;

    typedef struct packed {
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   owner;
        logic              used;
    } t_cell;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_ROT,
        CMD_EDIT
    } t_cmd_op;

    // broadcast to the cell row
    typedef struct packed {
        t_cmd_op          op;
        logic [IDX_W-1:0] pos;
        t_cell            wr;
        logic             ins;
        t_cell            ins_data;
        logic [1:0]       del;
    } t_cell_cmd;

endpackage

// ===== rtl/vpa_cell.sv =====
module vpa_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [vpa_pkg::IDX_W-1:0] i_index,
    input  vpa_pkg::t_cell_cmd       i_cmd,
    input  vpa_pkg::t_cell           i_left,
    input  vpa_pkg::t_cell           i_right,
    input  vpa_pkg::t_cell           i_right2,
    output vpa_pkg::t_cell           o_cell
);
    import vpa_pkg::*;

    t_cell r_cell;
    t_cell n_cell;
    logic [IDX_W:0] w_idx;
    logic [IDX_W:0] w_pos;
    logic [IDX_W:0] w_pos1;

    assign w_idx  = {1'b0, i_index};
    assign w_pos  = {1'b0, i_cmd.pos};
    assign w_pos1 = w_pos + (IDX_W+1)'(1);

    always_comb begin
        n_cell = r_cell;
        case (i_cmd.op)
            CMD_ROT: begin
                n_cell = i_right;
            end
            CMD_EDIT: begin
                if (w_idx == w_pos) begin
                    n_cell = i_cmd.wr;
                end else if (i_cmd.ins && w_idx == w_pos1) begin
                    n_cell = i_cmd.ins_data;
                end else if (i_cmd.ins && w_idx > w_pos1) begin
                    n_cell = i_left;
                end else if (!i_cmd.ins && w_idx > w_pos && i_cmd.del == 2'd1) begin
                    n_cell = i_right;
                end else if (!i_cmd.ins && w_idx > w_pos && i_cmd.del == 2'd2) begin
                    n_cell = i_right2;
                end
            end
            default: begin
                n_cell = r_cell;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '{start: '0, size: RESET_TOTAL, owner: '0, used: 1'b0};
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== rtl/vpa_util_div.sv =====
module vpa_util_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vpa_pkg::SIZE_W-1:0] i_used,
    input  logic [vpa_pkg::SIZE_W-1:0] i_total,
    output logic                       o_done,
    output logic [6:0]                 o_util
);
    import vpa_pkg::*;

    logic [22:0] r_rem;
    logic [22:0] r_sh;
    logic [6:0]  r_q;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [22:0] w_prod;
    logic        w_ge;

    // used * 100 = used*64 + used*32 + used*4
    assign w_prod = 23'({i_used, 6'b0}) + 23'({i_used, 5'b0}) + 23'({i_used, 2'b0});
    assign w_ge   = (r_rem >= r_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= '0;
            r_rem  <= '0;
            r_sh   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q <= '0;
                if (i_total == '0) begin
                    r_done <= 1'b1;
                end else if (i_used >= i_total) begin
                    r_q    <= 7'd100;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= w_prod;
                    r_sh   <= {1'b0, i_total, 6'b0};
                    r_cnt  <= 3'd6;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_sh;
                end
                r_q  <= {r_q[5:0], w_ge};
                r_sh <= {1'b0, r_sh[22:1]};
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_util = r_q;

endmodule

// ===== rtl/variable_partition_allocator_unit.sv =====
// Flow: from accept to result valid, a rotation of the cell row to search, an edit step,
//   a second rotation to gather the metrics, and a shift-subtract division (which ends early
//   when the total is zero or not above the used size).
// The next transaction is taken only once the current one has reached the output
//   register. Reset: table is one free block of 1024 units.
module variable_partition_allocator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [vpa_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_opcode,
    input  logic [vpa_pkg::ID_W-1:0]   i_process_id,
    input  logic [vpa_pkg::SIZE_W-1:0] i_request_size,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [3:0]                 o_status,
    output logic [vpa_pkg::SIZE_W-1:0] o_start_address,
    output logic [vpa_pkg::CNT_W-1:0]  o_block_count,
    output logic [vpa_pkg::SIZE_W-1:0] o_free_total,
    output logic [vpa_pkg::SIZE_W-1:0] o_max_hole,
    output logic [vpa_pkg::SIZE_W-1:0] o_used_total,
    output logic [vpa_pkg::SIZE_W-1:0] o_scattered_free,
    output logic [6:0]                 o_utilization_percent,
    output logic [vpa_pkg::SIZE_W-1:0] o_allocations_done,
    output logic [vpa_pkg::SIZE_W-1:0] o_allocations_failed
);
    import vpa_pkg::*;
    `include "variable_partition_allocator_unit_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_DECIDE,
        S_SCAN2,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [SIZE_W-1:0] CNT_MAX = '1;

    t_state r_state;
    logic [1:0]        r_fit;
    logic [SIZE_W-1:0] r_total;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_cursor;
    logic [SIZE_W-1:0] r_succ;
    logic [SIZE_W-1:0] r_fail;

    logic [1:0]        r_op;
    logic [ID_W-1:0]   r_id;
    logic [SIZE_W-1:0] r_need;
    logic [IDX_W-1:0]  r_p;

    // search captures
    logic              r_a_ok, r_b_ok;
    logic [IDX_W-1:0]  r_a_k, r_b_k;
    logic [SIZE_W-1:0] r_a_start, r_a_size, r_b_start, r_b_size;
    logic              r_own_found;
    logic [IDX_W-1:0]  r_own_k;
    logic [SIZE_W-1:0] r_own_start, r_own_size;
    logic              r_own_prev_free;
    logic [SIZE_W-1:0] r_own_prev_start, r_own_prev_size;
    logic              r_nxt_free;
    logic [SIZE_W-1:0] r_nxt_size;
    logic              r_prev_used;
    logic [SIZE_W-1:0] r_prev_start, r_prev_size;

    // metrics
    logic [SIZE_W-1:0] r_free, r_large, r_used;
    logic [3:0]        r_status;
    logic [SIZE_W-1:0] r_addr;
    logic [6:0]        r_util;

    t_cell     w_cells [MAX_BLOCKS];
    t_cell_cmd w_cmd;
    t_cell     w_head;
    logic      w_valid, w_fit, w_upd_a, w_own_hit;
    logic      w_div_done;
    logic [6:0] w_util;

    // decision logic
    logic              w_pick_ok;
    logic [IDX_W-1:0]  w_pick_k;
    logic [SIZE_W-1:0] w_pick_start, w_pick_size, w_rem;
    logic              w_edit;
    logic [CNT_W-1:0]  n_count;
    logic [IDX_W:0]    w_k1;
    logic [CNT_W-1:0]  w_cnt_m1;

    // cell row
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        localparam int LEFT   = (g + MAX_BLOCKS - 1) % MAX_BLOCKS;
        localparam int RIGHT  = (g + 1) % MAX_BLOCKS;
        localparam int RIGHT2 = (g + 2) % MAX_BLOCKS;
        vpa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (IDX_W'(g)),
            .i_cmd    (w_cmd),
            .i_left   (w_cells[LEFT]),
            .i_right  (w_cells[RIGHT]),
            .i_right2 (w_cells[RIGHT2]),
            .o_cell   (w_cells[g])
        );
    end

    vpa_util_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_START),
        .i_used  (r_used),
        .i_total (r_total),
        .o_done  (w_div_done),
        .o_util  (w_util)
    );

    assign w_head    = w_cells[0];
    assign w_valid   = {1'b0, r_p} < r_count;
    assign w_fit     = w_valid && !w_head.used && (w_head.size >= r_need);
    assign w_own_hit = w_valid && w_head.used && (w_head.owner == r_id) && !r_own_found;

    always_comb begin
        case (r_fit)
            FIT_BEST:  w_upd_a = w_fit && (!r_a_ok || w_head.size < r_a_size);
            FIT_WORST: w_upd_a = w_fit && (!r_a_ok || w_head.size > r_a_size);
            default:   w_upd_a = w_fit && !r_a_ok;
        endcase
    end

    always_comb begin
        if (r_fit == FIT_NEXT && r_b_ok) begin
            w_pick_ok    = 1'b1;
            w_pick_k     = r_b_k;
            w_pick_start = r_b_start;
            w_pick_size  = r_b_size;
        end else begin
            w_pick_ok    = r_a_ok;
            w_pick_k     = r_a_k;
            w_pick_start = r_a_start;
            w_pick_size  = r_a_size;
        end
        w_rem = w_pick_size - r_need;
    end

    // edit broadcast and new count in the decide cycle
    always_comb begin
        w_cmd    = '{op: CMD_HOLD, pos: '0, wr: '0, ins: 1'b0, ins_data: '0, del: 2'd0};
        w_edit   = 1'b0;
        n_count  = r_count;
        case (r_op)
            OP_ALLOC: begin
                if (r_need != '0 && !r_own_found && w_pick_ok &&
                    !(w_rem != '0 && r_count >= CNT_W'(MAX_BLOCKS))) begin
                    w_edit       = 1'b1;
                    w_cmd.pos    = w_pick_k;
                    w_cmd.wr     = '{start: w_pick_start, size: r_need, owner: r_id,
                                     used: 1'b1};
                    w_cmd.ins    = (w_rem != '0);
                    w_cmd.ins_data = '{start: w_pick_start + r_need, size: w_rem,
                                       owner: '0, used: 1'b0};
                    n_count      = r_count + CNT_W'(w_rem != '0);
                end
            end
            OP_FREE: begin
                if (r_own_found) begin
                    w_edit    = 1'b1;
                    w_cmd.pos = r_own_prev_free ? (r_own_k - IDX_W'(1)) : r_own_k;
                    w_cmd.wr  = '{start: r_own_prev_free ? r_own_prev_start : r_own_start,
                                  size: r_own_size
                                        + (r_own_prev_free ? r_own_prev_size : '0)
                                        + (r_nxt_free ? r_nxt_size : '0),
                                  owner: '0, used: 1'b0};
                    w_cmd.del = 2'(r_own_prev_free) + 2'(r_nxt_free);
                    n_count   = r_count - CNT_W'(r_own_prev_free) - CNT_W'(r_nxt_free);
                end
            end
            OP_RESTART: begin
                w_edit    = 1'b1;
                w_cmd.pos = '0;
                w_cmd.wr  = '{start: '0, size: r_total, owner: '0, used: 1'b0};
                n_count   = CNT_W'(1);
            end
            default: begin
                w_edit = 1'b0;
            end
        endcase
        if (r_state == S_SCAN1 || r_state == S_SCAN2) begin
            w_cmd.op = CMD_ROT;
        end else if (r_state == S_DECIDE && w_edit) begin
            w_cmd.op = CMD_EDIT;
        end else begin
            w_cmd.op = CMD_HOLD;
        end
    end

    assign w_k1     = {1'b0, w_pick_k} + (IDX_W+1)'(1);
    assign w_cnt_m1 = n_count - CNT_W'(1);

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fit       <= FIT_FIRST;
            r_total     <= RESET_TOTAL;
            r_count     <= CNT_W'(1);
            r_cursor    <= '0;
            r_succ      <= '0;
            r_fail      <= '0;
            o_out_valid <= 1'b0;
            r_p         <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FIT_POLICY) begin
                    r_fit <= i_cfg_data[1:0];
                end else begin
                    r_total <= i_cfg_data;
                end
            end
            // S_DONE drives the valid flag itself
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_opcode;
                        r_id    <= i_process_id;
                        r_need  <= i_request_size;
                        r_p     <= '0;
                        r_a_ok  <= 1'b0;
                        r_b_ok  <= 1'b0;
                        r_own_found <= 1'b0;
                        r_nxt_free  <= 1'b0;
                        r_free  <= '0;
                        r_large <= '0;
                        r_used  <= '0;
                        r_state <= S_SCAN1;
                    end
                end
                S_SCAN1: begin
                    r_prev_used  <= w_head.used;
                    r_prev_start <= w_head.start;
                    r_prev_size  <= w_head.size;
                    if (w_upd_a) begin
                        r_a_ok    <= 1'b1;
                        r_a_k     <= r_p;
                        r_a_start <= w_head.start;
                        r_a_size  <= w_head.size;
                    end
                    if (w_fit && !r_b_ok && r_p >= r_cursor) begin
                        r_b_ok    <= 1'b1;
                        r_b_k     <= r_p;
                        r_b_start <= w_head.start;
                        r_b_size  <= w_head.size;
                    end
                    if (w_own_hit) begin
                        r_own_found      <= 1'b1;
                        r_own_k          <= r_p;
                        r_own_start      <= w_head.start;
                        r_own_size       <= w_head.size;
                        r_own_prev_free  <= (r_p != '0) && !r_prev_used;
                        r_own_prev_start <= r_prev_start;
                        r_own_prev_size  <= r_prev_size;
                    end
                    if (r_own_found && w_valid &&
                        {1'b0, r_p} == {1'b0, r_own_k} + (IDX_W+1)'(1)) begin
                        r_nxt_free <= !w_head.used;
                        r_nxt_size <= w_head.size;
                    end
                    if (w_valid) begin
                        if (w_head.used) begin
                            r_used <= r_used + w_head.size;
                        end else begin
                            r_free <= r_free + w_head.size;
                            if (w_head.size > r_large) begin
                                r_large <= w_head.size;
                            end
                        end
                    end
                    r_p <= r_p + IDX_W'(1);
                    if (r_p == LAST_POS) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_count <= n_count;
                    r_addr  <= (r_op == OP_ALLOC && w_edit) ? w_pick_start : '0;
                    case (r_op)
                        OP_ALLOC: begin
                            if (r_need == '0) begin
                                r_status <= STS_ZERO_SIZE;
                            end else if (r_own_found) begin
                                r_status <= STS_DUPLICATE_ID;
                            end else if (!w_pick_ok) begin
                                r_status <= (r_free >= r_need) ? STS_FAIL_FRAG
                                                               : STS_FAIL_SHORT;
                                if (r_fail != CNT_MAX) begin
                                    r_fail <= r_fail + SIZE_W'(1);
                                end
                            end else if (!w_edit) begin
                                r_status <= STS_TABLE_FULL;
                            end else begin
                                r_status <= STS_ALLOCATED;
                                r_cursor <= ({1'b0, w_k1} < {1'b0, w_cnt_m1})
                                            ? w_k1[IDX_W-1:0] : w_cnt_m1[IDX_W-1:0];
                                if (r_succ != CNT_MAX) begin
                                    r_succ <= r_succ + SIZE_W'(1);
                                end
                            end
                        end
                        OP_FREE: begin
                            if (r_own_found) begin
                                r_status <= STS_FREED;
                                r_cursor <= '0;
                            end else begin
                                r_status <= STS_FREE_IGNORED;
                            end
                        end
                        OP_RESTART: begin
                            r_status <= STS_RESTARTED;
                            r_cursor <= '0;
                            r_succ   <= '0;
                            r_fail   <= '0;
                        end
                        default: begin
                            r_status <= STS_FREE_IGNORED;
                        end
                    endcase
                    r_free  <= '0;
                    r_large <= '0;
                    r_used  <= '0;
                    r_p     <= '0;
                    r_state <= S_SCAN2;
                end
                S_SCAN2: begin
                    if (w_valid) begin
                        if (w_head.used) begin
                            r_used <= r_used + w_head.size;
                        end else begin
                            r_free <= r_free + w_head.size;
                            if (w_head.size > r_large) begin
                                r_large <= w_head.size;
                            end
                        end
                    end
                    r_p <= r_p + IDX_W'(1);
                    if (r_p == LAST_POS) begin
                        r_state <= S_DIV_START;
                    end
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_util  <= w_util;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid           <= 1'b1;
                        o_status              <= r_status;
                        o_start_address       <= r_addr;
                        o_block_count         <= r_count;
                        o_free_total          <= r_free;
                        o_max_hole            <= r_large;
                        o_used_total          <= r_used;
                        o_scattered_free      <= r_free - r_large;
                        o_utilization_percent <= r_util;
                        o_allocations_done    <= r_succ;
                        o_allocations_failed  <= r_fail;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `VPA_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, (r_count != '0) && (r_count <= CNT_W'(MAX_BLOCKS)), "block count out of range")
    `VPA_ASSERT_IMPLY(a_cursor_in_table, i_clk, i_rst_n, r_state == S_IDLE, {1'b0, r_cursor} < r_count, "next-fit cursor beyond table")
    `VPA_ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, o_out_valid, o_status <= STS_TABLE_FULL, "status code out of range")
    `VPA_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_SCAN1, "transaction did not start a scan")

endmodule
